FILE: hw/rtl/mafm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mafm_pkg;

  localparam int unsigned CurW     = 16;
  localparam int unsigned PwrW     = 10;
  localparam int unsigned SpdW     = 24;
  localparam int unsigned ErrW     = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 23;

  localparam logic [7:0]  OcRunMax = 8'hFF;
  localparam logic [11:0] StRunMax = 12'hFFF;
  localparam logic [2:0]  LeRunMax = 3'h7;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_WINDOW = 1'b1
  } mafm_op_e;

  typedef enum logic [1:0] {
    MODE_OTHER = 2'd0,
    MODE_JOG   = 2'd1,
    MODE_CYCLE = 2'd2
  } mafm_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CURRENT_LIMIT    = 3'd0,
    CFG_CURRENT_HITS     = 3'd1,
    CFG_STALL_POWER      = 3'd2,
    CFG_STALL_SPEED      = 3'd3,
    CFG_STALL_HITS       = 3'd4,
    CFG_SMALL_ERROR      = 3'd5,
    CFG_LARGE_ERROR      = 3'd6,
    CFG_LARGE_ERROR_HITS = 3'd7
  } mafm_cfg_idx_e;

  typedef struct packed {
    logic [15:0] current_limit;
    logic [7:0]  current_hits;
    logic [9:0]  stall_power;
    logic [15:0] stall_speed;
    logic [11:0] stall_hits;
    logic [22:0] small_error;
    logic [22:0] large_error;
    logic [2:0]  large_error_hits;
  } mafm_cfg_t;

  // per-axis run counters, one memory word
  typedef struct packed {
    logic [7:0]  oc_run;
    logic [11:0] st_run;
    logic [2:0]  le_run;
  } mafm_state_t;

  // sample held in the evaluate stage, magnitudes already taken
  typedef struct packed {
    mafm_op_e        op;
    logic [1:0]      axis;
    logic [CurW-1:0] cur;
    logic [PwrW-1:0] pwr;
    logic [SpdW-1:0] spd_mag;
    logic [ErrW-1:0] err_mag;
    mafm_mode_e      mode;
  } mafm_item_t;

  typedef struct packed {
    logic alarm;
    logic panic;
    logic warn;
    logic estop;
    logic muted;
  } mafm_flags_t;

  function automatic logic [23:0] mag24(input logic [23:0] v);
    logic [23:0] r;
    r = v[23] ? (~v + 24'd1) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mafm_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mafm_sample_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [1:0]         axis_index;
  logic [15:0]        motor_current;
  logic [9:0]         drive_power;
  logic signed [23:0] belt_speed;
  logic signed [23:0] position_error;
  logic [1:0]         machine_mode;

  modport source (
    output valid, op, axis_index, motor_current, drive_power, belt_speed,
           position_error, machine_mode,
    input  ready
  );
  modport sink (
    input  valid, op, axis_index, motor_current, drive_power, belt_speed,
           position_error, machine_mode,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/mafm_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mafm_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_axis;
  logic       current_alarm;
  logic       stall_panic;
  logic       large_error_warn;
  logic       emergency_stop;
  logic       axis_muted;

  modport source (
    output valid, result_axis, current_alarm, stall_panic, large_error_warn,
           emergency_stop, axis_muted,
    input  ready
  );
  modport sink (
    input  valid, result_axis, current_alarm, stall_panic, large_error_warn,
           emergency_stop, axis_muted,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/mafm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mafm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mafm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module mafm_cfg
  import mafm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [CfgIdxW-1:0]  idx_i,
  input  wire logic [CfgDataW-1:0] wdata_i,
  output mafm_cfg_t                cfg_o
);

  mafm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (mafm_cfg_idx_e'(idx_i))
        CFG_CURRENT_LIMIT:    cfg_d.current_limit    = wdata_i[15:0];
        CFG_CURRENT_HITS:     cfg_d.current_hits     = wdata_i[7:0];
        CFG_STALL_POWER:      cfg_d.stall_power      = wdata_i[9:0];
        CFG_STALL_SPEED:      cfg_d.stall_speed      = wdata_i[15:0];
        CFG_STALL_HITS:       cfg_d.stall_hits       = wdata_i[11:0];
        CFG_SMALL_ERROR:      cfg_d.small_error      = wdata_i[22:0];
        CFG_LARGE_ERROR:      cfg_d.large_error      = wdata_i[22:0];
        CFG_LARGE_ERROR_HITS: cfg_d.large_error_hits = wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_limit    <= 16'd4000;
      cfg_q.current_hits     <= 8'd150;
      cfg_q.stall_power      <= 10'd450;
      cfg_q.stall_speed      <= 16'd102;
      cfg_q.stall_hits       <= 12'd3000;
      cfg_q.small_error      <= 23'd1024;
      cfg_q.large_error      <= 23'd15360;
      cfg_q.large_error_hits <= 3'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mafm_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module mafm_eval
  import mafm_pkg::*;
(
  input  wire mafm_item_t  item_i,
  input  wire mafm_cfg_t   cfg_i,
  input  wire mafm_state_t state_i,
  input  wire logic        mute_i,
  input  wire logic        in_range_i,
  output mafm_state_t      state_o,
  output logic             mute_o,
  output mafm_flags_t      flags_o
);

  logic        moving;
  logic        oc_hit, st_hit, oc_trip, st_trip, small_hit, le_hit;
  logic        mute_oc, mute_st;
  logic [7:0]  oc_inc;
  logic [11:0] st_inc;
  logic [2:0]  le_inc;

  always_comb begin
    moving = (item_i.mode == MODE_JOG) || (item_i.mode == MODE_CYCLE);

    oc_inc  = (state_i.oc_run < OcRunMax) ? state_i.oc_run + 8'd1 : OcRunMax;
    oc_hit  = (item_i.cur > cfg_i.current_limit) && !mute_i;
    oc_trip = oc_hit && (oc_inc > cfg_i.current_hits);
    mute_oc = mute_i || oc_trip;

    st_inc  = (state_i.st_run < StRunMax) ? state_i.st_run + 12'd1 : StRunMax;
    st_hit  = (item_i.pwr > cfg_i.stall_power) &&
              (item_i.spd_mag < {8'd0, cfg_i.stall_speed}) && !mute_oc;
    st_trip = st_hit && (st_inc > cfg_i.stall_hits);
    mute_st = mute_oc || st_trip;

    small_hit = (item_i.err_mag > {1'b0, cfg_i.small_error}) && moving;

    le_inc = (state_i.le_run < LeRunMax) ? state_i.le_run + 3'd1 : LeRunMax;
    le_hit = (item_i.err_mag > {1'b0, cfg_i.large_error}) && (item_i.mode == MODE_CYCLE);

    state_o.oc_run = oc_hit ? oc_inc : 8'd0;
    // a tripped stall run restarts from zero
    state_o.st_run = (st_hit && !st_trip) ? st_inc : 12'd0;
    state_o.le_run = le_hit ? le_inc : 3'd0;
    mute_o         = mute_st || small_hit;

    flags_o = '0;
    if (in_range_i && (item_i.op == OP_SAMPLE)) begin
      flags_o.alarm = oc_trip && moving;
      flags_o.panic = st_trip;
      flags_o.warn  = le_hit;
      flags_o.estop = le_hit && (le_inc > cfg_i.large_error_hits);
      flags_o.muted = mute_o;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/motor_axis_fault_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// Fault monitor for up to AXES belt motors. Takes one transaction per clock while the
// result sink keeps up: the accepting edge reads the axis's run counters from a RAM
// with registered read and loads the evaluate stage, which applies the overcurrent,
// stall and position-error rules; the edge on which the output register is free writes
// the counters back and loads the output register. A write-back register forwards
// counters when the same axis arrives on consecutive cycles, so sustained throughput is
// one item per cycle whenever the result sink keeps up. Mute flags and per-axis counter
// valid bits live in flops cleared by reset; a window transaction clears all mute flags
// at once. Configuration registers may be written only while the block is idle.
module motor_axis_fault_monitor
  import mafm_pkg::*;
#(
  parameter int unsigned AXES = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  mafm_sample_if.sink              sample_i,
  mafm_result_if.source            result_o
);

  localparam int unsigned AW = (AXES > 1) ? $clog2(AXES) : 1;

  mafm_cfg_t   cfg;
  mafm_item_t  s1_q;
  logic        s1_valid_q;
  logic [AXES-1:0] mute_q, cnt_valid_q;
  logic        wb_valid_q;
  logic [AW-1:0] wb_addr_q;
  mafm_state_t wb_data_q;
  mafm_state_t ram_rdata, state_cur, state_next;
  mafm_flags_t flags;
  logic        mute_cur, mute_next;
  logic        in_accept, s1_fire, out_free, in_range, ram_we;
  logic [AW-1:0] s1_addr, rd_addr;

  logic       out_valid_q;
  logic [1:0] out_axis_q;
  mafm_flags_t out_flags_q;

  mafm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  assign out_free       = !out_valid_q || result_o.ready;
  assign s1_fire        = s1_valid_q && out_free;
  assign sample_i.ready = !s1_valid_q || out_free;
  assign in_accept      = sample_i.valid && sample_i.ready;

  assign rd_addr  = AW'(sample_i.axis_index);
  assign s1_addr  = AW'(s1_q.axis);
  assign in_range = 32'(s1_q.axis) < AXES;
  assign ram_we   = s1_fire && in_range && (s1_q.op == OP_SAMPLE);

  mafm_ram #(
    .WIDTH ($bits(mafm_state_t)),
    .DEPTH (AXES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (state_next),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // last write may have landed on the same edge as this item's read
  always_comb begin
    if (wb_valid_q && (wb_addr_q == s1_addr)) begin
      state_cur = wb_data_q;
    end else if (in_range && cnt_valid_q[s1_addr]) begin
      state_cur = ram_rdata;
    end else begin
      state_cur = '0;
    end
    mute_cur = in_range ? mute_q[s1_addr] : 1'b0;
  end

  mafm_eval u_eval (
    .item_i     (s1_q),
    .cfg_i      (cfg),
    .state_i    (state_cur),
    .mute_i     (mute_cur),
    .in_range_i (in_range),
    .state_o    (state_next),
    .mute_o     (mute_next),
    .flags_o    (flags)
  );

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.op      <= mafm_op_e'(sample_i.op);
      s1_q.axis    <= sample_i.axis_index;
      s1_q.cur     <= sample_i.motor_current;
      s1_q.pwr     <= sample_i.drive_power;
      s1_q.spd_mag <= mag24(sample_i.belt_speed);
      s1_q.err_mag <= mag24(sample_i.position_error);
      s1_q.mode    <= mafm_mode_e'(sample_i.machine_mode);
    end
    if (ram_we) begin
      wb_addr_q <= s1_addr;
      wb_data_q <= state_next;
    end
    if (s1_fire) begin
      out_axis_q  <= s1_q.axis;
      out_flags_q <= flags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wb_valid_q  <= 1'b0;
      mute_q      <= '0;
      cnt_valid_q <= '0;
    end else begin
      if (sample_i.ready) begin
        s1_valid_q <= sample_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (ram_we) begin
        wb_valid_q           <= 1'b1;
        cnt_valid_q[s1_addr] <= 1'b1;
        mute_q[s1_addr]      <= mute_next;
      end
      if (s1_fire && (s1_q.op == OP_WINDOW)) begin
        mute_q <= '0;
      end
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.result_axis      = out_axis_q;
  assign result_o.current_alarm    = out_flags_q.alarm;
  assign result_o.stall_panic      = out_flags_q.panic;
  assign result_o.large_error_warn = out_flags_q.warn;
  assign result_o.emergency_stop   = out_flags_q.estop;
  assign result_o.axis_muted       = out_flags_q.muted;

endmodule

`default_nettype wire

FILE: test/motor_axis_fault_monitor_tb.sv
`timescale 1ns / 1ps

module motor_axis_fault_monitor_tb;
  import mafm_pkg::*;

  localparam int unsigned NumAxes    = 4;
  localparam int unsigned HoldCycles = 150;

  typedef struct {
    mafm_op_e    op;
    logic [1:0]  axis;
    logic [15:0] current;
    logic [9:0]  power;
    logic [23:0] speed;
    logic [23:0] pos_err;
    logic [1:0]  mode;
    int unsigned gap;
  } sample_t;

  typedef struct packed {
    logic [1:0] axis;
    logic       alarm;
    logic       panic;
    logic       warn;
    logic       estop;
    logic       muted;
  } fault_flags_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  mafm_sample_if sample_bus ();
  mafm_result_if result_bus ();

  motor_axis_fault_monitor #(
    .AXES(NumAxes)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .sample_i   (sample_bus),
    .result_o   (result_bus)
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of the thresholds
  logic [15:0] lim_current;
  logic [7:0]  lim_current_hits;
  logic [9:0]  lim_stall_power;
  logic [15:0] lim_stall_speed;
  logic [11:0] lim_stall_hits;
  logic [22:0] lim_small_error;
  logic [22:0] lim_large_error;
  logic [2:0]  lim_large_hits;

  // predictor copy of the per-axis state
  logic        mute_flag       [NumAxes];
  logic [7:0]  overcurrent_run [NumAxes];
  logic [11:0] stall_run       [NumAxes];
  logic [2:0]  large_error_run [NumAxes];

  sample_t      sample_backlog[$];
  fault_flags_t awaited_flags[$];
  sample_t      on_bus;
  int unsigned  gap_count;
  int unsigned  samples_queued;
  bit           gap_override;
  int           fault_count;
  int unsigned  hold_requests;
  int unsigned  holds_done;
  int unsigned  hold_left;
  int unsigned  stall_left;
  int unsigned  results_seen;
  int unsigned  sink_pause;

  function automatic logic [23:0] magnitude(logic [23:0] v);
    return v[23] ? 24'(24'd0 - v) : v;
  endfunction

  function automatic fault_flags_t predict_fault_flags(sample_t s);
    fault_flags_t f;
    logic [23:0]  speed_mag;
    logic [23:0]  err_mag;
    logic         moving;
    int unsigned  a;
    f = '0;
    f.axis = s.axis;
    if (s.op == OP_WINDOW) begin
      for (int i = 0; i < NumAxes; i++) mute_flag[i] = 1'b0;
      return f;
    end
    a = s.axis;
    if (a >= NumAxes) return f;
    speed_mag = magnitude(s.speed);
    err_mag   = magnitude(s.pos_err);
    moving    = (s.mode == MODE_JOG) || (s.mode == MODE_CYCLE);

    if (s.current > lim_current && !mute_flag[a]) begin
      if (overcurrent_run[a] != '1) overcurrent_run[a] = overcurrent_run[a] + 1'b1;
      if (overcurrent_run[a] > lim_current_hits) begin
        f.alarm = moving;
        mute_flag[a] = 1'b1;
      end
    end else begin
      overcurrent_run[a] = '0;
    end

    if (s.power > lim_stall_power && speed_mag < lim_stall_speed && !mute_flag[a]) begin
      if (stall_run[a] != '1) stall_run[a] = stall_run[a] + 1'b1;
      if (stall_run[a] > lim_stall_hits) begin
        f.panic = 1'b1;
        mute_flag[a] = 1'b1;
        stall_run[a] = '0;
      end
    end else begin
      stall_run[a] = '0;
    end

    if (err_mag > lim_small_error && moving) mute_flag[a] = 1'b1;

    // large error run ignores the mute flag
    if (err_mag > lim_large_error && s.mode == MODE_CYCLE) begin
      if (large_error_run[a] != '1) large_error_run[a] = large_error_run[a] + 1'b1;
      f.warn  = 1'b1;
      f.estop = large_error_run[a] > lim_large_hits;
    end else begin
      large_error_run[a] = '0;
    end

    f.muted = mute_flag[a];
    return f;
  endfunction

  function automatic void check_field(string field, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      fault_count++;
      $error("%s: expected %0d, actual %0d", field, want, got);
    end
  endfunction

  function automatic void compare_flags(fault_flags_t want);
    check_field("result_axis", want.axis, result_bus.result_axis);
    check_field("current_alarm", want.alarm, result_bus.current_alarm);
    check_field("stall_panic", want.panic, result_bus.stall_panic);
    check_field("large_error_warn", want.warn, result_bus.large_error_warn);
    check_field("emergency_stop", want.estop, result_bus.emergency_stop);
    check_field("axis_muted", want.muted, result_bus.axis_muted);
  endfunction

  // driver: one transaction at a time from the backlog, gap drawn per item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bus.valid <= 1'b0;
      gap_count <= 0;
    end else begin
      if (sample_bus.valid && sample_bus.ready) begin
        awaited_flags.push_back(predict_fault_flags(on_bus));
      end
      if (!sample_bus.valid || sample_bus.ready) begin
        if (sample_backlog.size() == 0) begin
          sample_bus.valid <= 1'b0;
        end else if (gap_count < sample_backlog[0].gap) begin
          sample_bus.valid <= 1'b0;
          gap_count <= gap_count + 1;
        end else begin
          on_bus                    <= sample_backlog[0];
          sample_bus.op             <= sample_backlog[0].op;
          sample_bus.axis_index     <= sample_backlog[0].axis;
          sample_bus.motor_current  <= sample_backlog[0].current;
          sample_bus.drive_power    <= sample_backlog[0].power;
          sample_bus.belt_speed     <= sample_backlog[0].speed;
          sample_bus.position_error <= sample_backlog[0].pos_err;
          sample_bus.machine_mode   <= sample_backlog[0].mode;
          sample_bus.valid          <= 1'b1;
          gap_count <= 0;
          void'(sample_backlog.pop_front());
        end
      end
    end
  end

  // monitor: checks every result transaction, stalls at random, long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      holds_done <= 0;
      results_seen <= 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        results_seen <= results_seen + 1;
        if (awaited_flags.size() == 0) begin
          fault_count++;
          $error("result for axis %0d with no transaction pending", result_bus.result_axis);
        end else begin
          compare_flags(awaited_flags.pop_front());
        end
      end
      if (holds_done != hold_requests) begin
        holds_done <= holds_done + 1;
        hold_left <= HoldCycles;
        result_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        if (hold_left == 1) result_bus.ready <= 1'b1;
      end else if (result_bus.valid && result_bus.ready) begin
        sink_pause = ((results_seen / 100) % 4 == 1) ? 0 : $urandom_range(19, 0);
        result_bus.ready <= (sink_pause == 0);
        stall_left <= sink_pause;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        if (stall_left == 1) result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  function automatic int unsigned pick_above(int unsigned limit, int unsigned top);
    return (limit >= top) ? top : $urandom_range(top, limit + 1);
  endfunction

  function automatic int unsigned pick_below(int unsigned limit);
    return (limit == 0) ? 0 : $urandom_range(limit - 1, 0);
  endfunction

  function automatic logic [23:0] with_sign(int unsigned mag);
    if (mag >= 32'h800000) return 24'h800000;
    return $urandom_range(1, 0) ? 24'(24'd0 - 24'(mag)) : 24'(mag);
  endfunction

  function automatic void queue_sample(sample_t s);
    s.gap = (gap_override || (samples_queued / 40) % 4 == 2) ? 0 : $urandom_range(19, 0);
    sample_backlog.push_back(s);
    samples_queued++;
  endfunction

  function automatic void queue_item(mafm_op_e op, logic [1:0] axis, logic [15:0] current,
                                     logic [9:0] power, logic [23:0] speed,
                                     logic [23:0] pos_err, logic [1:0] mode);
    sample_t s;
    s.op = op;
    s.axis = axis;
    s.current = current;
    s.power = power;
    s.speed = speed;
    s.pos_err = pos_err;
    s.mode = mode;
    queue_sample(s);
  endfunction

  // a run of samples aimed at one fault on one axis, with some noise mixed in
  function automatic void queue_random_burst();
    int unsigned scenario;
    int unsigned kind;
    int unsigned run_len;
    logic [1:0]  home_axis;
    sample_t     s;
    scenario = $urandom_range(9, 0);
    run_len = (scenario == 9) ? 1 : $urandom_range(12, 1);
    home_axis = 2'($urandom_range(3, 0));
    if ($urandom_range(3, 0) == 0) queue_item(OP_WINDOW, home_axis, '0, '0, '0, '0, MODE_OTHER);
    repeat (run_len) begin
      kind = (scenario == 8) ? $urandom_range(7, 1) : scenario;
      s.op = OP_SAMPLE;
      s.axis = ($urandom_range(4, 0) == 0) ? 2'($urandom_range(3, 0)) : home_axis;
      s.current = 16'($urandom_range(lim_current, 0));
      s.power = 10'($urandom_range(lim_stall_power, 0));
      s.speed = with_sign($urandom_range(32'h800000, lim_stall_speed));
      s.pos_err = with_sign($urandom_range(lim_small_error, 0));
      s.mode = 2'($urandom_range(3, 0));
      case (kind)
        0: begin
          s.op = mafm_op_e'($urandom_range(1, 0));
          s.current = 16'($urandom);
          s.power = 10'($urandom);
          s.speed = 24'($urandom);
          s.pos_err = 24'($urandom);
        end
        1: begin
          s.current = 16'(pick_above(lim_current, 16'hFFFF));
          s.mode = 2'($urandom_range(2, 1));
        end
        2: s.current = 16'(pick_above(lim_current, 16'hFFFF));
        3, 4: begin
          s.power = 10'(pick_above(lim_stall_power, 10'h3FF));
          s.speed = with_sign(pick_below(lim_stall_speed));
        end
        5, 6: begin
          s.mode = MODE_CYCLE;
          s.pos_err = with_sign(pick_above(lim_large_error, 32'h800000));
        end
        7: begin
          s.mode = 2'($urandom_range(2, 1));
          s.pos_err = with_sign(pick_above(lim_small_error, 32'h800000));
        end
        default: s.op = OP_WINDOW;
      endcase
      queue_sample(s);
    end
  endfunction

  task automatic write_setting(mafm_cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CURRENT_LIMIT:    lim_current      = value[15:0];
      CFG_CURRENT_HITS:     lim_current_hits = value[7:0];
      CFG_STALL_POWER:      lim_stall_power  = value[9:0];
      CFG_STALL_SPEED:      lim_stall_speed  = value[15:0];
      CFG_STALL_HITS:       lim_stall_hits   = value[11:0];
      CFG_SMALL_ERROR:      lim_small_error  = value[22:0];
      CFG_LARGE_ERROR:      lim_large_error  = value[22:0];
      CFG_LARGE_ERROR_HITS: lim_large_hits   = value[2:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int unsigned cur_lim, int unsigned cur_hits,
                                int unsigned st_pwr, int unsigned st_spd,
                                int unsigned st_hits, int unsigned sm_err,
                                int unsigned lg_err, int unsigned lg_hits);
    write_setting(CFG_CURRENT_LIMIT, 23'(cur_lim));
    write_setting(CFG_CURRENT_HITS, 23'(cur_hits));
    write_setting(CFG_STALL_POWER, 23'(st_pwr));
    write_setting(CFG_STALL_SPEED, 23'(st_spd));
    write_setting(CFG_STALL_HITS, 23'(st_hits));
    write_setting(CFG_SMALL_ERROR, 23'(sm_err));
    write_setting(CFG_LARGE_ERROR, 23'(lg_err));
    write_setting(CFG_LARGE_ERROR_HITS, 23'(lg_hits));
    @(negedge clk_i);
  endtask

  // sampled at the falling edge so the driver and monitor updates have settled
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (sample_backlog.size() != 0 || sample_bus.valid || awaited_flags.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_random_phase(int unsigned count);
    int unsigned stop_at;
    stop_at = samples_queued + count;
    while (samples_queued < stop_at) queue_random_burst();
    wait_for_drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    sample_bus.valid = 1'b0;
    sample_bus.op = OP_SAMPLE;
    sample_bus.axis_index = '0;
    sample_bus.motor_current = '0;
    sample_bus.drive_power = '0;
    sample_bus.belt_speed = '0;
    sample_bus.position_error = '0;
    sample_bus.machine_mode = MODE_OTHER;
    result_bus.ready = 1'b0;
    fault_count = 0;
    hold_requests = 0;
    samples_queued = 0;
    gap_override = 1'b0;
    lim_current = 16'd4000;
    lim_current_hits = 8'd150;
    lim_stall_power = 10'd450;
    lim_stall_speed = 16'd102;
    lim_stall_hits = 12'd3000;
    lim_small_error = 23'd1024;
    lim_large_error = 23'd15360;
    lim_large_hits = 3'd5;
    for (int i = 0; i < NumAxes; i++) begin
      mute_flag[i] = 1'b0;
      overcurrent_run[i] = '0;
      stall_run[i] = '0;
      large_error_run[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: short thresholds so each fault shows within a few samples
    apply_settings(1000, 2, 100, 500, 3, 1024, 15360, 2);
    queue_item(OP_WINDOW, 2'd0, 16'd0, 10'd0, 24'd0, 24'd0, MODE_OTHER);
    repeat (3) queue_item(OP_SAMPLE, 2'd0, 16'hFFFF, 10'd0, 24'h7FFFFF, 24'd0, MODE_JOG);
    // overcurrent on a muted axis clears the run
    queue_item(OP_SAMPLE, 2'd0, 16'hFFFF, 10'd0, 24'h7FFFFF, 24'd0, MODE_JOG);
    queue_item(OP_WINDOW, 2'd3, 16'hFFFF, 10'h3FF, 24'hFFFFFF, 24'hFFFFFF, 2'd3);
    // overcurrent outside jog or cycle mutes without alarm
    repeat (3) queue_item(OP_SAMPLE, 2'd1, 16'd1001, 10'd0, 24'd1000, 24'd0, MODE_OTHER);
    repeat (4) queue_item(OP_SAMPLE, 2'd2, 16'd0, 10'h3FF, 24'hFFFE0D, 24'd0, MODE_OTHER);
    // most negative error in cycle: warn, mute, then emergency stop
    repeat (4) queue_item(OP_SAMPLE, 2'd3, 16'd0, 10'd0, 24'd5000, 24'h800000, MODE_CYCLE);
    queue_item(OP_WINDOW, 2'd1, 16'd0, 10'd0, 24'd0, 24'd0, MODE_OTHER);
    // unknown mode behaves like other
    queue_item(OP_SAMPLE, 2'd3, 16'd999, 10'h3FF, 24'd0, 24'h7FFFFF, 2'd3);
    queue_item(OP_SAMPLE, 2'd0, 16'd0, 10'd0, 24'd800, 24'd1025, MODE_JOG);
    queue_item(OP_SAMPLE, 2'd1, 16'd0, 10'd0, 24'd800, 24'hFFFC00, MODE_JOG);
    queue_item(OP_SAMPLE, 2'd2, 16'd0, 10'h3FF, 24'h800000, 24'd0, MODE_JOG);
    wait_for_drain();

    apply_settings(4000, 150, 450, 102, 3000, 1024, 15360, 5);
    run_random_phase(50);
    apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
    run_random_phase(50);
    apply_settings(65535, 255, 1023, 65535, 4095, 8388607, 8388607, 7);
    run_random_phase(50);
    apply_settings(2000, 3, 500, 2000, 4, 4096, 20000, 2);
    run_random_phase(50);
    apply_settings(60000, 1, 10, 65535, 1, 0, 1, 0);
    run_random_phase(50);
    apply_settings(1, 7, 1022, 1, 2, 8388606, 8388606, 6);
    run_random_phase(50);
    repeat (3) begin
      apply_settings($urandom_range(65535, 0), $urandom_range(6, 0), $urandom_range(1023, 0),
                     $urandom_range(65535, 0), $urandom_range(8, 0),
                     $urandom_range(8388607, 0), $urandom_range(8388607, 0),
                     $urandom_range(7, 0));
      run_random_phase(50);
    end

    // back-pressure: results held off while samples keep coming without gaps
    apply_settings(2000, 3, 500, 2000, 4, 4096, 20000, 2);
    gap_override = 1'b1;
    hold_requests++;
    while (samples_queued % 64 != 0 || sample_backlog.size() < 48) queue_random_burst();
    gap_override = 1'b0;
    wait_for_drain();

    // overcurrent run saturates at its top, then a lower tolerance trips at once
    apply_settings(100, 255, 1023, 0, 4095, 8388607, 8388607, 7);
    queue_item(OP_WINDOW, 2'd0, 16'd0, 10'd0, 24'd0, 24'd0, MODE_OTHER);
    repeat (260) queue_item(OP_SAMPLE, 2'd0, 16'($urandom_range(65535, 101)),
                            10'($urandom), 24'($urandom), 24'($urandom), MODE_JOG);
    wait_for_drain();
    write_setting(CFG_CURRENT_HITS, 23'd200);
    @(negedge clk_i);
    queue_item(OP_SAMPLE, 2'd0, 16'hFFFF, 10'd0, 24'd0, 24'd0, MODE_CYCLE);
    wait_for_drain();

    repeat (8) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mafm_pkg.sv
hw/rtl/mafm_sample_if.sv
hw/rtl/mafm_result_if.sv
hw/rtl/mafm_ram.sv
hw/rtl/mafm_cfg.sv
hw/rtl/mafm_eval.sv
hw/rtl/motor_axis_fault_monitor.sv
test/motor_axis_fault_monitor_tb.sv
